>>> hw/rtl/p2h_pkg.sv
`default_nettype none

package p2h_pkg;

	// angle constants in Q16.16 degrees
	localparam logic [27:0] FULL_TURN = 28'd23592960;
	localparam logic [27:0] TWO_TURN  = 28'd47185920;
	localparam int          OCTANT_I  = 2949120;
	localparam logic [21:0] OCTANT    = 22'd2949120;

	// pi * 2^32 split as PI_INT * FULL_TURN + PI_REM
	localparam logic [9:0]  PI_INT    = 10'd571;
	localparam logic [24:0] PI_REM    = 25'd21457545;
	localparam logic [46:0] HALF_TURN = 47'd11796480;

	// reciprocal of 45 after dropping 2^19 from the full turn
	localparam logic [28:0] RECIP_45  = 29'd381774871;
	localparam int          SH_45     = 34;

	// reciprocal of 125 after dropping 2^3 from 1000
	localparam logic [29:0] RECIP_125 = 30'd549755814;
	localparam int          SH_125    = 36;

	localparam logic [31:0] ONE_Q31   = 32'h8000_0000;

	typedef logic signed [32:0] q31_t;

	typedef struct packed {
		q31_t s;
		q31_t c;
	} sc_t;

	// round a Q1.31 product back to Q1.31, half away from zero
	function automatic logic signed [33:0] rnd_q31(input logic signed [66:0] p);
		logic signed [66:0] b;
		b = p + (p[66] ? 67'sd1073741823 : 67'sd1073741824);
		return b[64:31];
	endfunction

	// Q1.31 to Q2.30 with rounding and clamp to plus or minus one
	function automatic logic [31:0] rot_out(input logic signed [35:0] v);
		logic signed [35:0] h;
		h = v + (v[35] ? 36'sd0 : 36'sd1);
		h = h >>> 1;
		if (h > 36'sd1073741824)
			return 32'h4000_0000;
		if (h < -36'sd1073741824)
			return 32'hC000_0000;
		return h[31:0];
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/p2h_sincos.sv
`default_nettype none

module p2h_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic signed [25:0] ang,
	output p2h_pkg::sc_t       sc
);
	import p2h_pkg::*;

	localparam int STEPS = 6;
	localparam int OCT_D = 16;

	logic [25:0] r_s1;
	logic [24:0] r_s2;
	logic [21:0] t_s3;
	logic [2:0]  oct_s3;
	logic [46:0] pa_s4;
	logic [31:0] pb_s4, pb_s5;
	logic [55:0] m_s5;
	logic [30:0] x_s6, x_s7;
	logic [61:0] sq_s7;
	logic [2:0]  oct_d [OCT_D];
	logic signed [33:0] ss_s20, cs_s20;
	logic [2:0]  oct_s20;
	sc_t         sc_s21;

	logic [27:0] v1;
	logic [27:0] r1;
	logic [27:0] r2;
	logic [2:0]  oct;
	logic [24:0] base;
	logic [24:0] f;
	logic [21:0] t;
	logic [46:0] nsum;

	// series stage registers, A holds term * x^2, B holds the reciprocal product
	logic [62:0] pa_sa [STEPS];
	logic [62:0] pc_sa [STEPS];
	logic [30:0] x2_sa [STEPS];
	logic signed [33:0] ss_sa [STEPS];
	logic signed [33:0] cs_sa [STEPS];
	logic [62:0] qa_sb [STEPS];
	logic [62:0] qc_sb [STEPS];
	logic [30:0] x2_sb [STEPS];
	logic signed [33:0] ss_sb [STEPS];
	logic signed [33:0] cs_sb [STEPS];
	logic [30:0] tsn [STEPS];
	logic [30:0] tcn [STEPS];
	logic signed [33:0] ss_nx [STEPS];
	logic signed [33:0] cs_nx [STEPS];

	function automatic sc_t quad_fix(input q31_t ss, input q31_t cs, input logic [2:0] o);
		q31_t sp, cp;
		sc_t  r;
		sp = o[0] ? cs : ss;
		cp = o[0] ? ss : cs;
		case (o[2:1])
			2'd0: begin r.s = sp;  r.c = cp;  end
			2'd1: begin r.s = cp;  r.c = -sp; end
			2'd2: begin r.s = -sp; r.c = -cp; end
			default: begin r.s = -cp; r.c = sp; end
		endcase
		return r;
	endfunction

	// reduction into one turn and octant fold
	always_comb begin
		v1 = {{2{ang[25]}}, ang} + TWO_TURN;
		r1 = (v1 >= TWO_TURN) ? v1 - TWO_TURN : v1;
		r2 = ({2'b0, r_s1} >= FULL_TURN) ? {2'b0, r_s1} - FULL_TURN : {2'b0, r_s1};
		oct = '0;
		for (int i = 1; i < 8; i++) begin
			if ({3'b0, r_s2} >= 28'(i * OCTANT_I))
				oct = 3'(i);
		end
		base = 25'(oct) * 25'(OCTANT);
		f = r_s2 - base;
		t = oct[0] ? 22'(25'(OCTANT) - f) : f[21:0];
		nsum = pa_s4 + HALF_TURN;
	end

	// front stages: reduction, degrees to radians, square
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= r1[25:0];
			r_s2   <= r2[24:0];
			t_s3   <= t;
			oct_s3 <= oct;
			pa_s4  <= 47'(t_s3) * 47'(PI_REM);
			pb_s4  <= 32'(t_s3) * 32'(PI_INT);
			m_s5   <= 56'(nsum[45:19]) * 56'(RECIP_45);
			pb_s5  <= pb_s4;
			x_s6   <= 31'(pb_s5 + 32'(m_s5 >> SH_45));
			sq_s7  <= 62'(x_s6) * 62'(x_s6);
			x_s7   <= x_s6;
		end
	end

	// octant travels beside the series
	always_ff @(posedge clk) begin
		if (en) begin
			oct_d[0] <= oct_s3;
			for (int i = 1; i < OCT_D; i++)
				oct_d[i] <= oct_d[i-1];
		end
	end

	// taylor series, one term pair per two stages
	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int unsigned DS = (2 * (j + 1)) * (2 * (j + 1) + 1);
		localparam int unsigned DC = (2 * (j + 1) - 1) * (2 * (j + 1));
		localparam int SHS = 31 + $clog2(DS);
		localparam int SHC = 31 + $clog2(DC);
		localparam logic [63:0] MSW = ((64'd1 << SHS) + 64'(DS) - 64'd1) / 64'(DS);
		localparam logic [63:0] MCW = ((64'd1 << SHC) + 64'(DC) - 64'd1) / 64'(DC);

		logic [31:0] ts_i, tc_i;
		logic [30:0] x2_i;
		logic signed [33:0] ss_i, cs_i;

		if (j == 0) begin : g_first
			assign ts_i = {1'b0, x_s7};
			assign tc_i = ONE_Q31;
			assign x2_i = sq_s7[61:31];
			assign ss_i = $signed({3'b0, x_s7});
			assign cs_i = $signed({2'b0, ONE_Q31});
		end else begin : g_next
			assign ts_i = {1'b0, tsn[j-1]};
			assign tc_i = {1'b0, tcn[j-1]};
			assign x2_i = x2_sb[j-1];
			assign ss_i = ss_nx[j-1];
			assign cs_i = cs_nx[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pa_sa[j] <= 63'(ts_i) * 63'(x2_i);
				pc_sa[j] <= 63'(tc_i) * 63'(x2_i);
				x2_sa[j] <= x2_i;
				ss_sa[j] <= ss_i;
				cs_sa[j] <= cs_i;
				qa_sb[j] <= 63'(pa_sa[j][61:31]) * 63'(MSW[31:0]);
				qc_sb[j] <= 63'(pc_sa[j][61:31]) * 63'(MCW[31:0]);
				x2_sb[j] <= x2_sa[j];
				ss_sb[j] <= ss_sa[j];
				cs_sb[j] <= cs_sa[j];
			end
		end

		assign tsn[j] = 31'(qa_sb[j] >> SHS);
		assign tcn[j] = 31'(qc_sb[j] >> SHC);

		// odd terms subtract, even terms add
		if (j % 2 == 0) begin : g_sub
			assign ss_nx[j] = ss_sb[j] - $signed({3'b0, tsn[j]});
			assign cs_nx[j] = cs_sb[j] - $signed({3'b0, tcn[j]});
		end else begin : g_add
			assign ss_nx[j] = ss_sb[j] + $signed({3'b0, tsn[j]});
			assign cs_nx[j] = cs_sb[j] + $signed({3'b0, tcn[j]});
		end
	end

	// final sums, then octant swap and quadrant signs
	always_ff @(posedge clk) begin
		if (en) begin
			ss_s20  <= ss_nx[STEPS-1];
			cs_s20  <= cs_nx[STEPS-1];
			oct_s20 <= oct_d[OCT_D-1];
			sc_s21  <= quad_fix(ss_s20[32:0], cs_s20[32:0], oct_s20);
		end
	end

	assign sc = sc_s21;

endmodule

`default_nettype wire

>>> hw/rtl/pose_to_homogeneous_matrix.sv
`default_nettype none

// Pose to homogeneous transform, upper 3x4 part.
// Input stream s_*: one pose per request, position in Q16.16 millimetres and
// three angles in Q10.16 degrees. Output stream m_*: nine Q2.30 rotation
// entries of Rx*Ry*Rz and three Q16.16 translations in metres.
// Throughput: one pose per cycle while the output queue has room. Every stage
// of the pipeline moves together under one enable; sine and cosine come from a
// 21-stage series unit per angle, the matrix products take six more stages.
// Path: an accepted request passes the sine and cosine stages and the matrix
// product stages, enters the output queue and shows on m_tvalid from then on.
// Stall: a two-entry output queue sits after the last stage. While it has room
// the pipeline keeps running and s_tready stays high; once it holds two
// results the whole pipeline holds and s_tready drops until one is taken.
// Reset: arst_n clears all valid bits and the queue; no item is in flight
// afterwards.
module pose_to_homogeneous_matrix (
	input  logic         clk,
	input  logic         arst_n,
	// pos_x_mm, pos_y_mm, pos_z_mm, angle_x_deg, angle_y_deg, angle_z_deg, pad
	input  logic [175:0] s_tdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// r00, r01, r02, r10, r11, r12, r20, r21, r22, trans_x_m, trans_y_m, trans_z_m
	output logic [383:0] m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready
);
	import p2h_pkg::*;

	localparam int PIPE_LEN = 27;
	localparam int TRN_D    = 24;

	logic en;
	logic push, pop;
	logic [PIPE_LEN-1:0] vld_q;
	logic [1:0]   cnt_q;
	logic [383:0] head_q, tail_q;
	logic [383:0] res;

	sc_t sc_x, sc_y, sc_z;

	logic [32:0] mag_s1 [3];
	logic        sgn_s1 [3];
	logic [58:0] prod_s2 [3];
	logic        sgn_s2 [3];
	logic [31:0] trn_s3 [3];
	logic [95:0] trn_d [TRN_D];

	logic signed [65:0] p_s22 [10];
	q31_t sy_s22, sz_s22, cz_s22;
	logic signed [33:0] rp_s23 [10];
	q31_t sy_s23, sz_s23, cz_s23;
	logic signed [66:0] p2_s24 [4];
	logic signed [33:0] rp_s24 [8];
	q31_t sy_s24;
	logic signed [33:0] r2_s25 [4];
	logic signed [33:0] rp_s25 [8];
	q31_t sy_s25;
	logic signed [35:0] sum_s26 [9];
	logic [31:0] rot_s27 [9];

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;
	assign push     = en && vld_q[PIPE_LEN-1];
	assign pop      = m_tvalid && m_tready;

	// valid bits ride along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LEN-2:0], s_tvalid};
		end
	end

	// sine and cosine per angle
	p2h_sincos u_sc_x (.clk(clk), .en(en), .ang($signed(s_tdata[121:96])),  .sc(sc_x));
	p2h_sincos u_sc_y (.clk(clk), .en(en), .ang($signed(s_tdata[147:122])), .sc(sc_y));
	p2h_sincos u_sc_z (.clk(clk), .en(en), .ang($signed(s_tdata[173:148])), .sc(sc_z));

	// translation: rounded divide by 1000 through a reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= (s_tdata[32*i+31] ?
					33'(33'd0 - {1'b1, s_tdata[32*i +: 32]}) :
					{1'b0, s_tdata[32*i +: 32]}) + 33'd500;
				sgn_s1[i]  <= s_tdata[32*i+31];
				prod_s2[i] <= 59'(mag_s1[i][31:3]) * 59'(RECIP_125);
				sgn_s2[i]  <= sgn_s1[i];
				trn_s3[i]  <= sgn_s2[i] ? 32'd0 - 32'(prod_s2[i] >> SH_125) :
					32'(prod_s2[i] >> SH_125);
			end
			trn_d[0] <= {trn_s3[2], trn_s3[1], trn_s3[0]};
			for (int i = 1; i < TRN_D; i++)
				trn_d[i] <= trn_d[i-1];
		end
	end

	// first products: sx*sy, cx*sy, cy*cz, cy*sz, cx*sz, cx*cz, sx*cy, sx*sz, sx*cz, cx*cy
	always_ff @(posedge clk) begin
		if (en) begin
			p_s22[0] <= sc_x.s * sc_y.s;
			p_s22[1] <= sc_x.c * sc_y.s;
			p_s22[2] <= sc_y.c * sc_z.c;
			p_s22[3] <= sc_y.c * sc_z.s;
			p_s22[4] <= sc_x.c * sc_z.s;
			p_s22[5] <= sc_x.c * sc_z.c;
			p_s22[6] <= sc_x.s * sc_y.c;
			p_s22[7] <= sc_x.s * sc_z.s;
			p_s22[8] <= sc_x.s * sc_z.c;
			p_s22[9] <= sc_x.c * sc_y.c;
			sy_s22 <= sc_y.s;
			sz_s22 <= sc_z.s;
			cz_s22 <= sc_z.c;
		end
	end

	// round, then second products with sxsy and cxsy
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 10; i++)
				rp_s23[i] <= rnd_q31(67'(p_s22[i]));
			sy_s23 <= sy_s22;
			sz_s23 <= sz_s22;
			cz_s23 <= cz_s22;
			p2_s24[0] <= 67'(rp_s23[0]) * 67'(cz_s23);
			p2_s24[1] <= 67'(rp_s23[0]) * 67'(sz_s23);
			p2_s24[2] <= 67'(rp_s23[1]) * 67'(cz_s23);
			p2_s24[3] <= 67'(rp_s23[1]) * 67'(sz_s23);
			for (int i = 0; i < 8; i++)
				rp_s24[i] <= rp_s23[i+2];
			sy_s24 <= sy_s23;
			for (int i = 0; i < 4; i++)
				r2_s25[i] <= rnd_q31(p2_s24[i]);
			rp_s25 <= rp_s24;
			sy_s25 <= sy_s24;
		end
	end

	// entry sums and output rounding
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s26[0] <= 36'(rp_s25[0]);
			sum_s26[1] <= -36'(rp_s25[1]);
			sum_s26[2] <= 36'(sy_s25);
			sum_s26[3] <= 36'(r2_s25[0]) + 36'(rp_s25[2]);
			sum_s26[4] <= 36'(rp_s25[3]) - 36'(r2_s25[1]);
			sum_s26[5] <= -36'(rp_s25[4]);
			sum_s26[6] <= 36'(rp_s25[5]) - 36'(r2_s25[2]);
			sum_s26[7] <= 36'(r2_s25[3]) + 36'(rp_s25[6]);
			sum_s26[8] <= 36'(rp_s25[7]);
			for (int i = 0; i < 9; i++)
				rot_s27[i] <= rot_out(sum_s26[i]);
		end
	end

	assign res = {trn_d[TRN_D-1], rot_s27[8], rot_s27[7], rot_s27[6], rot_s27[5],
		rot_s27[4], rot_s27[3], rot_s27[2], rot_s27[1], rot_s27[0]};

	// output queue count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// output queue entries
	always_ff @(posedge clk) begin
		if (push && (cnt_q == 2'd0 || (pop && cnt_q == 2'd1))) begin
			head_q <= res;
		end else if (pop) begin
			head_q <= tail_q;
		end
		if (push && !pop && cnt_q == 2'd1) begin
			tail_q <= res;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = head_q;

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count did not grow on push");

	a_cnt_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("queue count did not drop on pop");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2 && $stable(tail_q))
		else $error("full queue overwritten");

	a_r00_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sh4000_0000 &&
		$signed(m_tdata[31:0]) >= -32'sh4000_0000))
		else $error("rotation entry out of range");

endmodule

`default_nettype wire
